// ----- rtl/dsbm_pkg.sv -----
// Shared types, constants and helpers for the delta-sigma bitstream modulator.
// No dependencies; imported by every module of the block.
package dsbm_pkg;

  localparam int unsigned SampleW    = 16;
  localparam int unsigned GainW      = 8;
  localparam int unsigned FullScaleW = 24;
  localparam int unsigned WordsW     = 4;
  localparam int unsigned BitsPerWord = 32;
  localparam int unsigned BitCntW    = $clog2(BitsPerWord);
  localparam int unsigned DefMaxWords = 8;
  localparam int unsigned AccW       = 32;
  localparam int unsigned ProdW      = SampleW + GainW + 1;
  localparam int unsigned StepShiftBase = 4;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegWordsPerSample = 2'd0;
  localparam logic [CfgIdxW-1:0] RegGain           = 2'd1;
  localparam logic [CfgIdxW-1:0] RegFullScale      = 2'd2;
  localparam int unsigned CfgDataW = FullScaleW;

  localparam logic [WordsW-1:0]     WordsReset     = 4'd1;
  localparam logic [GainW-1:0]      GainReset      = 8'd64;
  localparam logic [FullScaleW-1:0] FullScaleReset = 24'd8388352;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;   // capture the input beat
    logic mul_en;    // average and apply gain
    logic tgt_en;    // clamp, form target, prime the error terms
    logic step_en;   // form the per-bit step
    logic bit_en;    // produce one modulated bit
    logic out_load;  // move a finished word into the output register
    logic out_last;  // the word being loaded closes the sample
  } dsbm_cmd_t;

  // Word count limited to the range 1 .. max_words.
  function automatic logic [WordsW-1:0] sat_words(input logic [WordsW-1:0] w,
                                                  input logic [WordsW-1:0] max_words);
    logic [WordsW-1:0] r;
    if (w == '0) begin
      r = {{(WordsW-1){1'b0}}, 1'b1};
    end else if (w > max_words) begin
      r = max_words;
    end else begin
      r = w;
    end
    return r;
  endfunction

endpackage

// ----- rtl/dsbm_ctrl.sv -----
// Sequencing controller of the delta-sigma modulator: handshakes, bit and word counters.
// Depends on dsbm_pkg; drives dsbm_datapath through a dsbm_cmd_t command bundle.
module dsbm_ctrl #(
  parameter int unsigned MAX_WORDS = dsbm_pkg::DefMaxWords
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [dsbm_pkg::WordsW-1:0] words_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output dsbm_pkg::dsbm_cmd_t         cmd_o
);
  import dsbm_pkg::*;

  localparam int unsigned WordIdxW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StMul  = 5'b00010,
    StTgt  = 5'b00100,
    StStep = 5'b01000,
    StRun  = 5'b10000
  } state_e;

  state_e               state_q, state_d;
  logic [BitCntW-1:0]   bit_cnt_q, bit_cnt_d;
  logic [WordIdxW-1:0]  word_cnt_q, word_cnt_d;
  logic                 out_valid_q, out_valid_d;
  logic                 last_bit, last_word, adv;

  assign last_bit  = (bit_cnt_q == BitCntW'(BitsPerWord - 1));
  assign last_word = (({{(WordsW-WordIdxW){1'b0}}, word_cnt_q} + WordsW'(1)) == words_i);
  // The final bit of a word waits while the output register still holds an untaken word.
  assign adv = (state_q == StRun) && !(last_bit && out_valid_q && !out_ready_i);

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    bit_cnt_d   = bit_cnt_q;
    word_cnt_d  = word_cnt_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = StMul;
        end
      end
      StMul: begin
        cmd_o.mul_en = 1'b1;
        state_d      = StTgt;
      end
      StTgt: begin
        cmd_o.tgt_en = 1'b1;
        state_d      = StStep;
      end
      StStep: begin
        cmd_o.step_en = 1'b1;
        bit_cnt_d     = '0;
        word_cnt_d    = '0;
        state_d       = StRun;
      end
      StRun: begin
        if (adv) begin
          cmd_o.bit_en = 1'b1;
          bit_cnt_d    = bit_cnt_q + BitCntW'(1);
          if (last_bit) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_last = last_word;
            out_valid_d    = 1'b1;
            word_cnt_d     = word_cnt_q + WordIdxW'(1);
            if (last_word) begin
              state_d = StIdle;
            end
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      bit_cnt_q   <= '0;
      word_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bit_cnt_q   <= bit_cnt_d;
      word_cnt_q  <= word_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- rtl/dsbm_datapath.sv -----
// Arithmetic of the delta-sigma modulator: gain, target, step, error loop, output word.
// Depends on dsbm_pkg; commanded by dsbm_ctrl through dsbm_cmd_t.
module dsbm_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dsbm_pkg::dsbm_cmd_t             cmd_i,
  input  logic [dsbm_pkg::WordsW-1:0]     words_i,
  input  logic [dsbm_pkg::GainW-1:0]      gain_i,
  input  logic [dsbm_pkg::FullScaleW-1:0] full_scale_i,
  input  logic signed [dsbm_pkg::SampleW-1:0] left_i,
  input  logic signed [dsbm_pkg::SampleW-1:0] right_i,
  output logic [dsbm_pkg::BitsPerWord-1:0] bit_word_o,
  output logic                            last_word_o
);
  import dsbm_pkg::*;

  localparam int unsigned AmpW = ProdW - 6;

  logic [SampleW-1:0]       left_q, right_q;
  logic signed [ProdW-1:0]  prod_q, prod_d;
  logic [AccW-1:0]          prev_q, diff_q, step_q;
  logic [AccW-1:0]          acc_q, acc_d;
  logic [AccW-1:0]          fmr_q, fpr_q;   // full_scale - ref and full_scale + ref
  logic [BitsPerWord-1:0]   shift_q, word_d;
  logic [BitsPerWord-1:0]   bit_word_q;
  logic                     last_word_q;

  logic [SampleW:0]         sum;
  logic [SampleW-1:0]       avg;
  logic signed [AmpW-1:0]   amp;
  logic [SampleW-1:0]       amp_clamp;
  logic [AccW-1:0]          target, fs_ext;
  logic [WordsW-1:0]        shamt;

  // Sum of the pair, shifted right by one: the upper sixteen bits of the 17-bit sum.
  assign sum = {left_q[SampleW-1], left_q} + {right_q[SampleW-1], right_q};
  assign avg = sum[SampleW:1];
  assign prod_d = $signed({{(ProdW-SampleW){avg[SampleW-1]}}, avg})
                * $signed({{(ProdW-GainW){1'b0}}, gain_i});

  assign amp = prod_q[ProdW-1:6];
  always_comb begin
    if (amp > $signed(AmpW'(32767))) begin
      amp_clamp = 16'h7FFF;
    end else if (amp < $signed(-AmpW'(32768))) begin
      amp_clamp = 16'h8000;
    end else begin
      amp_clamp = amp[SampleW-1:0];
    end
  end
  assign target = {{(AccW-SampleW-8){amp_clamp[SampleW-1]}}, amp_clamp, 8'd0};
  assign fs_ext = {{(AccW-FullScaleW){1'b0}}, full_scale_i};
  assign shamt  = words_i + WordsW'(StepShiftBase);

  // A negative accumulator emits a one and gains full_scale - ref; otherwise it loses
  // full_scale + ref.
  assign acc_d  = acc_q[AccW-1] ? (acc_q + fmr_q) : (acc_q - fpr_q);
  assign word_d = {shift_q[BitsPerWord-2:0], acc_q[AccW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      acc_q  <= '0;
    end else begin
      if (cmd_i.tgt_en) begin
        prev_q <= target;
      end
      if (cmd_i.bit_en) begin
        acc_q <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      left_q  <= left_i;
      right_q <= right_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (cmd_i.tgt_en) begin
      diff_q <= target - prev_q;
      fmr_q  <= fs_ext - target;
      fpr_q  <= fs_ext + target;
    end
    if (cmd_i.step_en) begin
      step_q <= AccW'($signed(diff_q) >>> shamt);
    end
    if (cmd_i.bit_en) begin
      shift_q <= word_d;
      fmr_q   <= fmr_q - step_q;
      fpr_q   <= fpr_q + step_q;
    end
    if (cmd_i.out_load) begin
      bit_word_q  <= word_d;
      last_word_q <= cmd_i.out_last;
    end
  end

  assign bit_word_o  = bit_word_q;
  assign last_word_o = last_word_q;

endmodule

// ----- rtl/delta_sigma_bitstream_modulator.sv -----
// Top level of the first-order delta-sigma bitstream modulator.
// Depends on dsbm_pkg, dsbm_ctrl and dsbm_datapath; holds the configuration registers.
//
// Usage: the input channel takes one stereo beat (left_i, right_i) when in_valid_i and
// in_ready_o are both high. Each beat yields words_per_sample output beats (bit_word_o,
// 32 modulated bits with the earliest bit in the MSB, and last_word_o set on the final
// one), moved when out_valid_o and out_ready_i are both high. A word count of zero acts
// as one and a count above MAX_WORDS acts as MAX_WORDS.
// Sequence: each sample passes an accept state and the setup states for gain multiply,
// target and step shift, then yields one modulated bit per cycle through the single
// error accumulator, while the output register does not stall the final bit of a word.
// Each word is loaded with its final bit. in_ready_o is high only between samples.
// The output register holds one finished word; when the receiver stalls, the final bit
// of the next word waits until that word is taken, so no word is lost.
// Reset clears the error accumulator, the previous target and all handshakes, and loads
// the configuration defaults (one word, unity gain, default full scale). Configuration
// writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at once; writes to unused
// indexes are ignored.
module delta_sigma_bitstream_modulator #(
  parameter int unsigned MAX_WORDS = dsbm_pkg::DefMaxWords
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [dsbm_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [dsbm_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [dsbm_pkg::SampleW-1:0] left_i,
  input  logic signed [dsbm_pkg::SampleW-1:0] right_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [dsbm_pkg::BitsPerWord-1:0]  bit_word_o,
  output logic                              last_word_o
);
  import dsbm_pkg::*;

  logic [WordsW-1:0]     words_q;
  logic [GainW-1:0]      gain_q;
  logic [FullScaleW-1:0] full_scale_q;
  logic [WordsW-1:0]     words_sat;
  dsbm_cmd_t             cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_q      <= WordsReset;
      gain_q       <= GainReset;
      full_scale_q <= FullScaleReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegWordsPerSample: words_q      <= cfg_wdata_i[WordsW-1:0];
        RegGain:           gain_q       <= cfg_wdata_i[GainW-1:0];
        RegFullScale:      full_scale_q <= cfg_wdata_i[FullScaleW-1:0];
        default: begin
        end
      endcase
    end
  end

  assign words_sat = sat_words(words_q, WordsW'(MAX_WORDS));

  dsbm_ctrl #(
    .MAX_WORDS(MAX_WORDS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .words_i    (words_sat),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd)
  );

  dsbm_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .words_i     (words_sat),
    .gain_i      (gain_q),
    .full_scale_i(full_scale_q),
    .left_i      (left_i),
    .right_i     (right_i),
    .bit_word_o  (bit_word_o),
    .last_word_o (last_word_o)
  );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking bench for delta_sigma_bitstream_modulator: stereo beats in, modulated words out.
// Needs dsbm_pkg and the block's RTL; predicts every word internally and checks it in order.
module testbench;
  import dsbm_pkg::*;

  localparam int MaxWords = DefMaxWords;
  localparam logic [CfgIdxW-1:0] RegUnused = 2'd3;
  localparam logic [CfgDataW-1:0] FullScaleMax = 24'hFFFFFF;
  localparam int MaxShown = 10;

  typedef struct {
    logic signed [SampleW-1:0] left;
    logic signed [SampleW-1:0] right;
  } stereo_t;

  typedef struct {
    logic [BitsPerWord-1:0] bits;
    logic                   last;
  } word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [SampleW-1:0] left_i = '0;
  logic signed [SampleW-1:0] right_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [BitsPerWord-1:0] bit_word_o;
  logic last_word_o;

  delta_sigma_bitstream_modulator u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .left_i      (left_i),
    .right_i     (right_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .bit_word_o  (bit_word_o),
    .last_word_o (last_word_o)
  );

  always #2 clk_i = ~clk_i;

  stereo_t sample_q[$];
  word_t   word_q[$];
  int      mismatches = 0;

  // Mirror of the block's registers and state.
  logic [WordsW-1:0]     mdl_words = WordsReset;
  logic [GainW-1:0]      mdl_gain = GainReset;
  logic [FullScaleW-1:0] mdl_full_scale = FullScaleReset;
  int                    mdl_prev_target = 0;
  int                    mdl_err_acc = 0;

  function automatic void modulate_sample(input logic signed [SampleW-1:0] l,
                                          input logic signed [SampleW-1:0] r);
    int    n_words, avg, amp, tgt, stp, ref_lvl, fs;
    word_t w;
    n_words = (mdl_words == 0) ? 1 : (int'(mdl_words) > MaxWords) ? MaxWords : int'(mdl_words);
    avg = (int'(l) + int'(r)) >>> 1;
    amp = (avg * int'(mdl_gain)) >>> 6;
    if (amp > 32767) amp = 32767;
    if (amp < -32768) amp = -32768;
    tgt = amp <<< 8;
    stp = (tgt - mdl_prev_target) >>> (StepShiftBase + n_words);
    mdl_prev_target = tgt;
    ref_lvl = tgt;
    fs = int'(mdl_full_scale);
    for (int j = 0; j < n_words; j++) begin
      w.bits = '0;
      for (int i = 0; i < BitsPerWord; i++) begin
        w.bits = w.bits << 1;
        if (mdl_err_acc < 0) begin
          w.bits[0] = 1'b1;
          mdl_err_acc = mdl_err_acc + (fs - ref_lvl);
        end else begin
          mdl_err_acc = mdl_err_acc - (fs + ref_lvl);
        end
        ref_lvl = ref_lvl + stp;
      end
      w.last = (j == n_words - 1);
      word_q.push_back(w);
    end
  endfunction

  // Input beat accepted at the last rising edge.
  logic in_taken = 1'b0;

  always @(posedge clk_i) begin
    word_t exp_w;
    if (!rst_ni) begin
      mdl_words = WordsReset;
      mdl_gain = GainReset;
      mdl_full_scale = FullScaleReset;
      mdl_prev_target = 0;
      mdl_err_acc = 0;
      in_taken <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegWordsPerSample: mdl_words = cfg_wdata_i[WordsW-1:0];
          RegGain:           mdl_gain = cfg_wdata_i[GainW-1:0];
          RegFullScale:      mdl_full_scale = cfg_wdata_i[FullScaleW-1:0];
          default: ;
        endcase
      end
      in_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) modulate_sample(left_i, right_i);
      if (out_valid_o && out_ready_i) begin
        if (word_q.size() == 0) begin
          if (mismatches < MaxShown)
            $display("%0t: unexpected word %h last %b", $realtime, bit_word_o, last_word_o);
          mismatches++;
        end else begin
          exp_w = word_q.pop_front();
          if (exp_w.bits !== bit_word_o || exp_w.last !== last_word_o) begin
            if (mismatches < MaxShown)
              $display("%0t: word mismatch: expected %h last %b, got %h last %b", $realtime,
                       exp_w.bits, exp_w.last, bit_word_o, last_word_o);
            mismatches++;
          end
        end
      end
    end
  end

  // Sender: bursts of beats separated by random gaps.
  int      burst_left = 0;
  int      gap_left = 0;
  stereo_t next_beat;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_taken) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (sample_q.size() != 0) begin
        next_beat = sample_q.pop_front();
        left_i <= next_beat.left;
        right_i <= next_beat.right;
        in_valid_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 6);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: always ready, coin-flip stalls, or long periodic stalls.
  int unsigned stall_cnt = 0;
  int unsigned stall_mode = 0;

  always @(negedge clk_i) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 97 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      default: out_ready_i <= (stall_cnt % 50) >= 35;
    endcase
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_beat(input int l, input int r);
    stereo_t s;
    s.left = SampleW'(l);
    s.right = SampleW'(r);
    sample_q.push_back(s);
  endtask

  // Mostly full-range samples, with corner values mixed in.
  task automatic push_random(input int n);
    int corner[4];
    corner = '{-32768, 32767, 0, -1};
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 9) == 0)
        push_beat(corner[$urandom_range(0, 3)], corner[$urandom_range(0, 3)]);
      else
        push_beat(int'($urandom), int'($urandom));
    end
  endtask

  task automatic wait_idle();
    while (sample_q.size() != 0 || in_valid_i || word_q.size() != 0 || !in_ready_o)
      @(negedge clk_i);
  endtask

  initial begin
    int words_plan[8];
    words_plan = '{1, 2, 3, 4, 8, 0, 12, 5};
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Default settings: extremes, rounding of odd sums, mixed signs.
    push_beat(0, 0);
    push_beat(32767, 32767);
    push_beat(-32768, -32768);
    push_beat(32767, -32768);
    push_beat(-32768, 32767);
    push_beat(-1, 0);
    push_beat(1, 0);
    push_beat(-1, -2);
    push_beat(12345, -23456);
    wait_idle();

    // Largest gain drives the gained value into saturation both ways.
    write_reg(RegGain, 255);
    push_beat(32767, 32767);
    push_beat(-32768, -32768);
    push_beat(200, 100);
    push_beat(-129, -129);
    wait_idle();

    // A word count of zero behaves as one.
    write_reg(RegWordsPerSample, 0);
    write_reg(RegGain, 0);
    write_reg(RegFullScale, 0);
    push_beat(1000, -5);
    wait_idle();

    // Counts above the maximum saturate.
    write_reg(RegWordsPerSample, 15);
    write_reg(RegGain, 128);
    write_reg(RegFullScale, FullScaleMax);
    push_beat(32767, 32767);
    push_beat(-32768, -32768);
    wait_idle();
    write_reg(RegWordsPerSample, 9);
    push_beat(-100, 300);
    wait_idle();

    // A write to the unused index must change nothing.
    write_reg(RegUnused, 24'h000001);
    push_beat(-20000, 7);
    wait_idle();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(RegWordsPerSample, CfgDataW'(words_plan[ph]));
      case (ph % 4)
        0: write_reg(RegGain, 64);
        1: write_reg(RegGain, 255);
        2: write_reg(RegGain, 0);
        default: write_reg(RegGain, CfgDataW'($urandom_range(0, 255)));
      endcase
      case (ph % 4)
        0: write_reg(RegFullScale, FullScaleReset);
        1: write_reg(RegFullScale, 0);
        2: write_reg(RegFullScale, FullScaleMax);
        default: write_reg(RegFullScale, CfgDataW'($urandom));
      endcase
      push_random(12);
      wait_idle();
    end

    repeat (300) @(negedge clk_i);
    if (word_q.size() != 0) begin
      if (mismatches < MaxShown) $display("%0d expected words never arrived", word_q.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
